// ===== src/mtf_pkg.sv =====
// package for the move-to-front focus list
// holds sizes, command codes and the command struct shared by the cell row
// no dependencies
package mtf_pkg;

    localparam int DEPTH = 16;
    localparam int ID_W  = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ACT_OPEN   = 2'd0,
        ACT_SWITCH = 2'd1,
        ACT_CLOSE  = 2'd2,
        ACT_NOP    = 2'd3
    } action_t;

    // per-transaction command broadcast to every cell
    typedef struct packed {
        logic            do_open;
        logic            do_switch;
        logic            do_close;
        logic [ID_W-1:0] id;
    } cmd_t;

endpackage

// ===== src/mtf_cell.sv =====
// one slot of the move-to-front list
// holds one id, compares it with the command id and shifts toward either neighbor
// depends on mtf_pkg
module mtf_cell
(
    input  logic                     clk,
    input  mtf_pkg::cmd_t            cmd,
    input  logic                     valid,
    input  logic                     found,
    input  logic                     hit_in,
    input  logic [mtf_pkg::ID_W-1:0] left_entry,
    input  logic [mtf_pkg::ID_W-1:0] right_entry,
    output logic                     hit_out,
    output logic [mtf_pkg::ID_W-1:0] entry
);

    logic [mtf_pkg::ID_W-1:0] entry_reg;
    logic [mtf_pkg::ID_W-1:0] entry_next;

    // first-match chain: hit_in means an earlier slot already matched
    assign hit_out = hit_in | (valid & (entry_reg == cmd.id));
    assign entry   = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.do_open || (cmd.do_switch && found && !hit_in))
        begin
            entry_next = left_entry;
        end
        else if (cmd.do_close && found && hit_out)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== src/move_to_front_focus_list_unit.sv =====
// top level of the move-to-front focus list
// a row of mtf_cell slots plus the entry count and the output register
// depends on mtf_pkg and mtf_cell
//
// usage:
//   input channel  in_valid / in_ready carries action and target_id
//   output channel out_valid / out_ready carries focused_id, list_empty,
//   target_found and open_dropped, one result per command
//   open pushes an id on the front (dropped and flagged when full), switch
//   moves the first match to the front, close removes the first match
//   every slot compares against the id at once and shifts toward its
//   neighbor in the same cycle, so every command is applied by all slots at once
//   result: registered, valid the cycle after the input transaction
//   throughput: one command per cycle while the receiver keeps up; the
//   single output register sets this figure
//   receiver stall: the result is held and in_ready drops until it is taken
//   reset: list is empty, no result pending; slot contents stay unknown and
//   are never read until written
module move_to_front_focus_list_unit
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               action,
    input  logic [mtf_pkg::ID_W-1:0] target_id,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [mtf_pkg::ID_W-1:0] focused_id,
    output logic                     list_empty,
    output logic                     target_found,
    output logic                     open_dropped
);

    localparam int DEPTH = mtf_pkg::DEPTH;
    localparam int ID_W  = mtf_pkg::ID_W;
    localparam int CNT_W = mtf_pkg::CNT_W;

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [ID_W-1:0]      focused_reg;
    logic                 empty_reg;
    logic                 found_reg;
    logic                 dropped_reg;

    logic                 accept;
    logic                 full;
    mtf_pkg::action_t     act;
    mtf_pkg::cmd_t        cmd;
    logic                 found;
    logic                 res_found;
    logic                 res_dropped;

    // per-slot wiring of the cell row
    logic [ID_W-1:0]      entries   [DEPTH];
    logic [DEPTH:0]       hit_chain;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign act      = mtf_pkg::action_t'(action);

    // commands are gated by the transaction, so cells hold when idle
    always_comb
    begin
        cmd.do_open   = 1'b0;
        cmd.do_switch = 1'b0;
        cmd.do_close  = 1'b0;
        cmd.id        = target_id;
        res_dropped   = 1'b0;
        case (act)
            mtf_pkg::ACT_OPEN:
            begin
                cmd.do_open = accept && !full;
                res_dropped = full;
            end
            mtf_pkg::ACT_SWITCH: cmd.do_switch = accept;
            mtf_pkg::ACT_CLOSE:  cmd.do_close  = accept;
            default:             cmd.do_open   = 1'b0;
        endcase
    end

    // first-match chain runs from the front slot to the back
    assign hit_chain[0] = 1'b0;
    assign found        = hit_chain[DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            localparam logic [CNT_W-1:0] CELL_IDX = CNT_W'(i);
            logic [ID_W-1:0] left_e;
            logic [ID_W-1:0] right_e;

            // front slot takes the new id, others take the slot ahead
            if (i == 0)
            begin : g_front
                assign left_e = target_id;
            end
            else
            begin : g_inner
                assign left_e = entries[i-1];
            end

            // back slot refills with don't-care data on close
            if (i == DEPTH - 1)
            begin : g_back
                assign right_e = entries[i];
            end
            else
            begin : g_mid
                assign right_e = entries[i+1];
            end

            mtf_cell u_cell
            (
                .clk         (clk),
                .cmd         (cmd),
                .valid       (CELL_IDX < count_reg),
                .found       (found),
                .hit_in      (hit_chain[i]),
                .left_entry  (left_e),
                .right_entry (right_e),
                .hit_out     (hit_chain[i+1]),
                .entry       (entries[i])
            );
        end
    endgenerate

    // entry count follows opens and successful closes
    always_comb
    begin
        count_next = count_reg;
        if (cmd.do_open)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.do_close && found)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign res_found = cmd.do_open || ((cmd.do_switch || cmd.do_close) && found);

    // output register: hold while the receiver stalls
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // front id after the command mirrors the front slot's next value
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (cmd.do_open || (cmd.do_switch && found))
            begin
                focused_reg <= target_id;
            end
            else if (cmd.do_close && found && hit_chain[1])
            begin
                focused_reg <= entries[(DEPTH > 1) ? 1 : 0];
            end
            else
            begin
                focused_reg <= entries[0];
            end
            empty_reg   <= (count_next == '0);
            found_reg   <= res_found;
            dropped_reg <= res_dropped;
        end
    end

    assign out_valid    = out_valid_reg;
    assign focused_id   = empty_reg ? '0 : focused_reg;
    assign list_empty   = empty_reg;
    assign target_found = found_reg;
    assign open_dropped = dropped_reg;

endmodule
